[hw/rtl/pcsc_pkg.sv]
// Shared types and codes for the pixel color space converter.
// No dependencies; imported by the top level, pcsc_ycc2rgb and pcsc_rgb2ycc.
`timescale 1ns / 1ps
`default_nettype none

package pcsc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT = 2'd1;

    typedef enum logic [1:0] {
        FMT_RGB  = 2'd0,
        FMT_RGBA = 2'd1,
        FMT_YCC  = 2'd2
    } t_fmt;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] a;
    } t_pix;

    typedef struct packed {
        logic valid;
        t_fmt ifmt;
        t_fmt ofmt;
    } t_ctl;

endpackage

`default_nettype wire

[hw/rtl/pixel_color_space_converter.sv]
// Pixel color space converter top level: format registers and 4-stage pipeline.
// A pixel transferred with i_start passes through stage registers s1 to s4 and is presented with o_valid.
// Throughput: one pixel per clock; o_busy is always low, the output cannot stall.
// Reset (synchronous, active low) clears the pipeline valid bits, formats to RGB.
// Depends on pcsc_pkg, pcsc_ycc2rgb, pcsc_rgb2ycc and pcsc_rndclp.
`timescale 1ns / 1ps
`default_nettype none

module pixel_color_space_converter #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pcsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pcsc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [7:0]                       i_first_in,
    input  wire logic [7:0]                       i_second_in,
    input  wire logic [7:0]                       i_third_in,
    input  wire logic [7:0]                       i_alpha_in,
    output logic                                  o_valid,
    output logic [7:0]                            o_first_out,
    output logic [7:0]                            o_second_out,
    output logic [7:0]                            o_third_out,
    output logic [7:0]                            o_alpha_out
);

    import pcsc_pkg::*;

    t_fmt r_ifmt;
    t_fmt r_ofmt;
    t_fmt w_wfmt;
    t_ctl w_in_ctl;
    t_pix w_in_pix;
    t_ctl w_mid_ctl;
    t_pix w_mid_pix;
    t_ctl w_out_ctl;
    t_pix w_out_pix;

    // code 3 behaves as RGB
    assign w_wfmt = (i_cfg_wdata == 2'd3) ? FMT_RGB : t_fmt'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ifmt <= FMT_RGB;
            r_ofmt <= FMT_RGB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INPUT_FORMAT:  r_ifmt <= w_wfmt;
                REG_OUTPUT_FORMAT: r_ofmt <= w_wfmt;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    assign w_in_ctl.valid = i_start & ~o_busy;
    assign w_in_ctl.ifmt  = r_ifmt;
    assign w_in_ctl.ofmt  = r_ofmt;
    assign w_in_pix.c0    = i_first_in;
    assign w_in_pix.c1    = i_second_in;
    assign w_in_pix.c2    = i_third_in;
    assign w_in_pix.a     = i_alpha_in;

    pcsc_ycc2rgb #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_ycc2rgb (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_in_ctl),
        .i_pix  (w_in_pix),
        .o_ctl  (w_mid_ctl),
        .o_pix  (w_mid_pix)
    );

    pcsc_rgb2ycc #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_rgb2ycc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_mid_ctl),
        .i_pix  (w_mid_pix),
        .o_ctl  (w_out_ctl),
        .o_pix  (w_out_pix)
    );

    assign o_valid      = w_out_ctl.valid;
    assign o_first_out  = w_out_pix.c0;
    assign o_second_out = w_out_pix.c1;
    assign o_third_out  = w_out_pix.c2;
    assign o_alpha_out  = w_out_pix.a;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##4 o_valid)
        else $error("transfer did not produce a result after 4 cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 4))
        else $error("result strobe without a matching input transfer");

    a_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_out_ctl.ofmt != FMT_RGBA) |-> (o_alpha_out == 8'd0))
        else $error("nonzero alpha on a non-RGBA result");

    a_ycc_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_out_ctl.ifmt == FMT_YCC && w_out_ctl.ofmt == FMT_YCC)
        |-> (o_first_out == $past(i_first_in, 4)))
        else $error("YCbCr pass-through altered luma");

endmodule

`default_nettype wire

[hw/rtl/pcsc_rndclp.sv]
// Round half away from zero from Q.F to integer, then clamp to 0..255.
// Combinational; used by both conversion stages. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pcsc_rndclp #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int W              = 28
) (
    input  wire logic signed [W-1:0] i_val,
    output logic             [7:0]   o_val
);

    localparam logic [W-1:0] HALF = W'(1) << (COEF_FRAC_BITS - 1);

    logic [W-1:0]                w_sum;
    logic [W-COEF_FRAC_BITS-1:0] w_int;

    assign w_sum = $unsigned(i_val) + HALF;
    assign w_int = w_sum[W-1:COEF_FRAC_BITS];

    // negative sums always end at or below zero
    always_comb begin
        if (i_val[W-1]) begin
            o_val = 8'd0;
        end else if (|w_int[W-COEF_FRAC_BITS-1:8]) begin
            o_val = 8'hFF;
        end else begin
            o_val = w_int[7:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pcsc_ycc2rgb.sv]
// Stages 1-2: YCbCr to RGB matrix (products, then sums with round/clamp).
// Depends on pcsc_pkg and pcsc_rndclp.
`timescale 1ns / 1ps
`default_nettype none

module pcsc_ycc2rgb #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pcsc_pkg::t_ctl i_ctl,
    input  wire pcsc_pkg::t_pix i_pix,
    output pcsc_pkg::t_ctl     o_ctl,
    output pcsc_pkg::t_pix     o_pix
);

    import pcsc_pkg::*;

    localparam int W_C = COEF_FRAC_BITS + 3;
    localparam int W_P = COEF_FRAC_BITS + 12;

    localparam longint unsigned K_RCR = ((64'd1402000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_GCB = ((64'd344136 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_GCR = ((64'd714136 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_BCB = ((64'd1772000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;

    localparam logic signed [W_C-1:0] C_RCR = W_C'(K_RCR);
    localparam logic signed [W_C-1:0] C_GCB = W_C'(K_GCB);
    localparam logic signed [W_C-1:0] C_GCR = W_C'(K_GCR);
    localparam logic signed [W_C-1:0] C_BCB = W_C'(K_BCB);

    logic signed [8:0]     w_cb;
    logic signed [8:0]     w_cr;

    t_ctl                  r_s1_ctl;
    t_pix                  r_s1_pix;
    logic signed [W_P-1:0] r_p_rcr;
    logic signed [W_P-1:0] r_p_gcb;
    logic signed [W_P-1:0] r_p_gcr;
    logic signed [W_P-1:0] r_p_bcb;

    logic signed [W_P-1:0] w_y;
    logic signed [W_P-1:0] w_r_sum;
    logic signed [W_P-1:0] w_g_sum;
    logic signed [W_P-1:0] w_b_sum;
    logic [7:0]            w_r;
    logic [7:0]            w_g;
    logic [7:0]            w_b;
    t_pix                  n_s2_pix;

    t_ctl                  r_s2_ctl;
    t_pix                  r_s2_pix;

    assign w_cb = $signed({1'b0, i_pix.c1}) - 9'sd128;
    assign w_cr = $signed({1'b0, i_pix.c2}) - 9'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
        end else begin
            r_s1_ctl.valid <= i_ctl.valid;
        end
        r_s1_ctl.ifmt <= i_ctl.ifmt;
        r_s1_ctl.ofmt <= i_ctl.ofmt;
        r_s1_pix      <= i_pix;
        r_p_rcr       <= W_P'(C_RCR) * W_P'(w_cr);
        r_p_gcb       <= W_P'(C_GCB) * W_P'(w_cb);
        r_p_gcr       <= W_P'(C_GCR) * W_P'(w_cr);
        r_p_bcb       <= W_P'(C_BCB) * W_P'(w_cb);
    end

    assign w_y     = $signed({4'd0, r_s1_pix.c0, {COEF_FRAC_BITS{1'b0}}});
    assign w_r_sum = w_y + r_p_rcr;
    assign w_g_sum = w_y - r_p_gcb - r_p_gcr;
    assign w_b_sum = w_y + r_p_bcb;

    pcsc_rndclp #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .W(W_P)) u_rc_r (
        .i_val(w_r_sum), .o_val(w_r)
    );
    pcsc_rndclp #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .W(W_P)) u_rc_g (
        .i_val(w_g_sum), .o_val(w_g)
    );
    pcsc_rndclp #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .W(W_P)) u_rc_b (
        .i_val(w_b_sum), .o_val(w_b)
    );

    // YCbCr in and out passes through untouched
    always_comb begin
        n_s2_pix = r_s1_pix;
        if (r_s1_ctl.ifmt == FMT_YCC && r_s1_ctl.ofmt != FMT_YCC) begin
            n_s2_pix.c0 = w_r;
            n_s2_pix.c1 = w_g;
            n_s2_pix.c2 = w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.valid <= 1'b0;
        end else begin
            r_s2_ctl.valid <= r_s1_ctl.valid;
        end
        r_s2_ctl.ifmt <= r_s1_ctl.ifmt;
        r_s2_ctl.ofmt <= r_s1_ctl.ofmt;
        r_s2_pix      <= n_s2_pix;
    end

    assign o_ctl = r_s2_ctl;
    assign o_pix = r_s2_pix;

endmodule

`default_nettype wire

[hw/rtl/pcsc_rgb2ycc.sv]
// Stages 3-4: RGB to YCbCr matrix, alpha selection and output register.
// Depends on pcsc_pkg and pcsc_rndclp.
`timescale 1ns / 1ps
`default_nettype none

module pcsc_rgb2ycc #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pcsc_pkg::t_ctl i_ctl,
    input  wire pcsc_pkg::t_pix i_pix,
    output pcsc_pkg::t_ctl      o_ctl,
    output pcsc_pkg::t_pix      o_pix
);

    import pcsc_pkg::*;

    localparam int W_C = COEF_FRAC_BITS + 3;
    localparam int W_P = COEF_FRAC_BITS + 12;

    localparam longint unsigned K_YR  = ((64'd299000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_YG  = ((64'd587000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_YB  = ((64'd114000 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_CBR = ((64'd168736 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_CBG = ((64'd331264 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_CRG = ((64'd418688 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned K_CRB = ((64'd81312 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;

    localparam logic signed [W_C-1:0] C_YR   = W_C'(K_YR);
    localparam logic signed [W_C-1:0] C_YG   = W_C'(K_YG);
    localparam logic signed [W_C-1:0] C_YB   = W_C'(K_YB);
    localparam logic signed [W_C-1:0] C_CBR  = W_C'(K_CBR);
    localparam logic signed [W_C-1:0] C_CBG  = W_C'(K_CBG);
    localparam logic signed [W_C-1:0] C_HALF = W_C'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [W_C-1:0] C_CRG  = W_C'(K_CRG);
    localparam logic signed [W_C-1:0] C_CRB  = W_C'(K_CRB);
    localparam logic signed [W_P-1:0] OFF    = W_P'(128) << COEF_FRAC_BITS;

    logic signed [8:0]     w_r;
    logic signed [8:0]     w_g;
    logic signed [8:0]     w_b;

    t_ctl                  r_s3_ctl;
    t_pix                  r_s3_pix;
    logic signed [W_P-1:0] r_p_yr;
    logic signed [W_P-1:0] r_p_yg;
    logic signed [W_P-1:0] r_p_yb;
    logic signed [W_P-1:0] r_p_cbr;
    logic signed [W_P-1:0] r_p_cbg;
    logic signed [W_P-1:0] r_p_cbb;
    logic signed [W_P-1:0] r_p_crr;
    logic signed [W_P-1:0] r_p_crg;
    logic signed [W_P-1:0] r_p_crb;

    logic signed [W_P-1:0] w_y_sum;
    logic signed [W_P-1:0] w_cb_sum;
    logic signed [W_P-1:0] w_cr_sum;
    logic [7:0]            w_y;
    logic [7:0]            w_cb;
    logic [7:0]            w_cr;
    t_pix                  n_s4_pix;

    t_ctl                  r_s4_ctl;
    t_pix                  r_s4_pix;

    assign w_r = $signed({1'b0, i_pix.c0});
    assign w_g = $signed({1'b0, i_pix.c1});
    assign w_b = $signed({1'b0, i_pix.c2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl.valid <= 1'b0;
        end else begin
            r_s3_ctl.valid <= i_ctl.valid;
        end
        r_s3_ctl.ifmt <= i_ctl.ifmt;
        r_s3_ctl.ofmt <= i_ctl.ofmt;
        r_s3_pix      <= i_pix;
        r_p_yr        <= W_P'(C_YR) * W_P'(w_r);
        r_p_yg        <= W_P'(C_YG) * W_P'(w_g);
        r_p_yb        <= W_P'(C_YB) * W_P'(w_b);
        r_p_cbr       <= W_P'(C_CBR) * W_P'(w_r);
        r_p_cbg       <= W_P'(C_CBG) * W_P'(w_g);
        r_p_cbb       <= W_P'(C_HALF) * W_P'(w_b);
        r_p_crr       <= W_P'(C_HALF) * W_P'(w_r);
        r_p_crg       <= W_P'(C_CRG) * W_P'(w_g);
        r_p_crb       <= W_P'(C_CRB) * W_P'(w_b);
    end

    assign w_y_sum  = r_p_yr + r_p_yg + r_p_yb;
    assign w_cb_sum = OFF - r_p_cbr - r_p_cbg + r_p_cbb;
    assign w_cr_sum = OFF + r_p_crr - r_p_crg - r_p_crb;

    pcsc_rndclp #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .W(W_P)) u_rc_y (
        .i_val(w_y_sum), .o_val(w_y)
    );
    pcsc_rndclp #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .W(W_P)) u_rc_cb (
        .i_val(w_cb_sum), .o_val(w_cb)
    );
    pcsc_rndclp #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .W(W_P)) u_rc_cr (
        .i_val(w_cr_sum), .o_val(w_cr)
    );

    always_comb begin
        n_s4_pix   = r_s3_pix;
        n_s4_pix.a = 8'd0;
        if (r_s3_ctl.ofmt == FMT_YCC) begin
            if (r_s3_ctl.ifmt != FMT_YCC) begin
                n_s4_pix.c0 = w_y;
                n_s4_pix.c1 = w_cb;
                n_s4_pix.c2 = w_cr;
            end
        end else if (r_s3_ctl.ofmt == FMT_RGBA) begin
            if (r_s3_ctl.ifmt == FMT_RGB) begin
                n_s4_pix.a = 8'hFF;
            end else if (r_s3_ctl.ifmt == FMT_RGBA) begin
                n_s4_pix.a = r_s3_pix.a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl.valid <= 1'b0;
        end else begin
            r_s4_ctl.valid <= r_s3_ctl.valid;
        end
        r_s4_ctl.ifmt <= r_s3_ctl.ifmt;
        r_s4_ctl.ofmt <= r_s3_ctl.ofmt;
        r_s4_pix      <= n_s4_pix;
    end

    assign o_ctl = r_s4_ctl;
    assign o_pix = r_s4_pix;

endmodule

`default_nettype wire
